>>> rtl/median_noise_residual_3x3_unit_assert.svh
// assertion macros shared by the median residual rtl
// depends on nothing; included by files that check their own logic
`ifndef MEDIAN_NOISE_RESIDUAL_3X3_UNIT_ASSERT_SVH
`define MEDIAN_NOISE_RESIDUAL_3X3_UNIT_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define MNR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("mnr assertion failed");

// antecedent holds, consequent must hold in the next cycle
`define MNR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("mnr assertion failed");

`endif

>>> rtl/mnr_pkg.sv
// types, constants and luma function for the median residual block
// no dependencies
package mnr_pkg;

   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 2'd2;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic [8:0]  GAIN_RESET   = 9'd5;

   localparam logic [12:0] ROW_SAT = 13'd8191;

   // floor(x / 100) as (x * 5243) >> 19, exact for x below 43699
   localparam logic [27:0] LUMA_MUL   = 28'd5243;
   localparam int          LUMA_SHIFT = 19;

   localparam int WIN_SIZE = 9;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pixel_type;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       flush_only;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       end_of_frame;
   } rsp_type;

   // control carried along the pipeline with each beat
   typedef struct packed {
      logic                valid;
      logic [WIN_SIZE-1:0] mask;
      logic                eof;
   } ctl_type;

   function automatic logic [7:0] luma(input pixel_type p);
      logic [14:0] s;
      logic [27:0] prod;
      s = 15'(p.r) * 15'd30 + 15'(p.g) * 15'd59 + 15'(p.b) * 15'd11;
      prod = 28'(s) * LUMA_MUL;
      return prod[LUMA_SHIFT +: 8];
   endfunction

endpackage

>>> rtl/median_noise_residual_3x3_unit.sv
// one beat per cycle while req_ready is high; the line store ram has one read and one
// write port; the window-completing beat passes stages s1 to s4 and the output register
// before rsp_valid; a pixel's result follows after image_width + 1 further stream beats
// reset: synchronous, clears counters, window cells and valids; registers return to
// 640 x 480 with gain 5; line store contents stay undefined until written
module median_noise_residual_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mnr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mnr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [mnr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mnr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

`include "median_noise_residual_3x3_unit_assert.svh"

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   // configuration
   logic [10:0]       image_width_ff;
   logic [12:0]       image_height_ff;
   logic signed [8:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mnr_pkg::WIDTH_RESET;
         image_height_ff <= mnr_pkg::HEIGHT_RESET;
         gain_ff         <= mnr_pkg::GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mnr_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[10:0];
            mnr_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[12:0];
            mnr_pkg::CSR_GAIN:         gain_ff         <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [ADDR_W:0] w_eff;
   logic [12:0]     h_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = (ADDR_W+1)'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = (ADDR_W+1)'(MAX_WIDTH);
      end else begin
         w_eff = (ADDR_W+1)'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? 13'd1 : image_height_ff;
   end

   // pipeline advance: stalls only when the output holds a beat and s4 has one too
   logic adv;
   logic s4_valid_ff;
   logic rsp_valid_ff;

   assign adv       = rsp_ready || !rsp_valid_ff || !s4_valid_ff;
   assign req_ready = adv;

   logic req_fire;
   assign req_fire = req_valid && adv;

   // stream position counters
   logic [ADDR_W-1:0] in_column_ff, in_column_in;
   logic [12:0]       in_row_ff, in_row_in;
   logic [ADDR_W-1:0] out_column_ff, out_column_in;
   logic [12:0]       out_row_ff, out_row_in;

   logic                         ignore;
   logic                         primed;
   logic                         eof_now;
   logic [ADDR_W:0]              col_inc;
   logic [ADDR_W:0]              out_col_inc;
   logic [13:0]                  out_row_inc;
   logic [2:0]                   vr;
   logic [2:0]                   vc;
   logic [mnr_pkg::WIN_SIZE-1:0] mask_now;
   mnr_pkg::pixel_type           px_now;

   always_comb begin
      ignore      = (in_row_ff < h_eff) && req_data.flush_only;
      primed      = (in_row_ff >= 13'd2) || (in_row_ff == 13'd1 && in_column_ff != '0);
      col_inc     = {1'b0, in_column_ff} + (ADDR_W+1)'(1);
      out_col_inc = {1'b0, out_column_ff} + (ADDR_W+1)'(1);
      out_row_inc = {1'b0, out_row_ff} + 14'd1;
      eof_now     = (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= w_eff);
      vr          = {out_row_inc < {1'b0, h_eff}, 1'b1, out_row_ff != '0};
      vc          = {out_col_inc < w_eff, 1'b1, out_column_ff != '0};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mask_now[i*3+j] = vr[j] && vc[i];
         end
      end
      if (in_row_ff < h_eff) begin
         px_now = '{r: req_data.pixel_red, g: req_data.pixel_green,
                    b: req_data.pixel_blue};
      end else begin
         px_now = '0;
      end

      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (req_fire && !ignore) begin
         if (col_inc >= w_eff) begin
            in_column_in = '0;
            if (in_row_ff < mnr_pkg::ROW_SAT) begin
               in_row_in = in_row_ff + 13'd1;
            end
         end else begin
            in_column_in = col_inc[ADDR_W-1:0];
         end
         if (primed) begin
            if (eof_now) begin
               in_column_in  = '0;
               in_row_in     = '0;
               out_column_in = '0;
               out_row_in    = '0;
            end else if (out_col_inc >= w_eff) begin
               out_column_in = '0;
               out_row_in    = out_row_inc[12:0];
            end else begin
               out_column_in = out_col_inc[ADDR_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   // stage 1: line store read returns
   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic [ADDR_W-1:0]  s1_col_ff;
   mnr_pkg::pixel_type s1_px_ff;
   mnr_pkg::ctl_type   s1_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_fire && !ignore;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_emit_ff <= primed;
         s1_col_ff  <= in_column_ff;
         s1_px_ff   <= px_now;
         s1_ctl_ff  <= '{valid: 1'b1, mask: mask_now, eof: eof_now};
      end
   end

   logic [47:0] ram_rd;
   logic [47:0] line_old;
   logic        s1_write;

   // entry holds {older row, newer row}
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [47:0]       fwd_data_ff;

   assign s1_write = s1_valid_ff && adv;
   assign line_old = (fwd_valid_ff && fwd_addr_ff == s1_col_ff) ? fwd_data_ff : ram_rd;

   mnr_ram #(
      .WIDTH (48),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data ({line_old[23:0], s1_px_ff}),
      .rd_en   (req_fire),
      .rd_addr (in_column_ff),
      .rd_data (ram_rd)
   );

   // last write bypasses a read issued in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_write) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         fwd_addr_ff <= s1_col_ff;
         fwd_data_ff <= {line_old[23:0], s1_px_ff};
      end
   end

   // stage 2: window cells, newest column enters cell 2
   mnr_pkg::pixel_type [2:0] cell_col [3];
   mnr_pkg::pixel_type [2:0] cell_in  [3];
   logic [2:0][7:0]          cell_luma [3];

   assign cell_in[2] = {s1_px_ff, line_old[23:0], line_old[47:24]};
   assign cell_in[1] = cell_col[2];
   assign cell_in[0] = cell_col[1];

   for (genvar c = 0; c < 3; c++) begin : g_cell
      mnr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_write),
         .col_in   (cell_in[c]),
         .col_out  (cell_col[c]),
         .luma_out (cell_luma[c])
      );
   end

   logic                                    s2_valid_ff;
   mnr_pkg::ctl_type                        s2_ctl_ff;
   mnr_pkg::pixel_type [mnr_pkg::WIN_SIZE-1:0] win;
   logic [mnr_pkg::WIN_SIZE-1:0][7:0]       win_luma;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            win[i*3+j]      = cell_col[i][j];
            win_luma[i*3+j] = cell_luma[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   // stage 3: median value
   logic                                       s3_valid_ff;
   mnr_pkg::ctl_type                           s3_ctl_ff;
   mnr_pkg::pixel_type [mnr_pkg::WIN_SIZE-1:0] s3_win_ff;
   logic [mnr_pkg::WIN_SIZE-1:0][7:0]          s3_luma_ff;
   logic [7:0]                                 med;

   mnr_median u_median (
      .clock   (clock),
      .en      (adv),
      .luma_in (win_luma),
      .mask_in (s2_ctl_ff.mask),
      .med     (med)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_win_ff  <= win;
         s3_luma_ff <= win_luma;
      end
   end

   // stage 4: pick median pixel, residual times gain
   mnr_pkg::pixel_type      medpix;
   mnr_pkg::pixel_type      centre;
   logic signed [2:0][8:0]  diff;
   logic signed [17:0]      s4_prod_ff [3];
   logic                    s4_eof_ff;

   always_comb begin
      medpix = '0;
      // last match in scan order: rows top first, then columns
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (s3_ctl_ff.mask[i*3+j] && s3_luma_ff[i*3+j] == med) begin
               medpix = s3_win_ff[i*3+j];
            end
         end
      end
      centre  = s3_win_ff[4];
      diff[0] = $signed({1'b0, centre.r}) - $signed({1'b0, medpix.r});
      diff[1] = $signed({1'b0, centre.g}) - $signed({1'b0, medpix.g});
      diff[2] = $signed({1'b0, centre.b}) - $signed({1'b0, medpix.b});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            s4_prod_ff[c] <= $signed(diff[c]) * gain_ff;
         end
         s4_eof_ff <= s3_ctl_ff.eof;
      end
   end

   // output register with clamp
   logic [2:0][7:0]  clamped;
   mnr_pkg::rsp_type rsp_data_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         priority if (s4_prod_ff[c] < 18'sd0) begin
            clamped[c] = 8'd0;
         end else if (s4_prod_ff[c] > 18'sd255) begin
            clamped[c] = 8'd255;
         end else begin
            clamped[c] = s4_prod_ff[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready || !rsp_valid_ff) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !rsp_valid_ff) begin
         rsp_data_ff <= '{out_red: clamped[0], out_green: clamped[1],
                          out_blue: clamped[2], end_of_frame: s4_eof_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MNR_ASSERT_NEXT(a_flush_in_frame_holds, clock, reset, req_fire && ignore,
      $stable(in_row_ff) && $stable(in_column_ff))
   `MNR_ASSERT_NEXT(a_eof_clears_counters, clock, reset,
      req_fire && !ignore && primed && eof_now,
      in_row_ff == '0 && in_column_ff == '0 && out_row_ff == '0 && out_column_ff == '0)
   `MNR_ASSERT_NEXT(a_stall_keeps_s4, clock, reset, s4_valid_ff && !adv,
      s4_valid_ff && $stable(s4_eof_ff))
   `MNR_ASSERT_NEXT(a_bypass_tracks_write, clock, reset, s1_write,
      fwd_valid_ff && fwd_addr_ff == $past(s1_col_ff))

endmodule

>>> rtl/mnr_ram.sv
// generic single write port ram with registered read
// no dependencies
module mnr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mnr_cell.sv
// one window column cell: holds three rows of a column, hands it on when shifted
// depends on mnr_pkg
module mnr_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  mnr_pkg::pixel_type [2:0]    col_in,
   output mnr_pkg::pixel_type [2:0]    col_out,
   output logic [2:0][7:0]             luma_out
);

   mnr_pkg::pixel_type [2:0] column_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (shift_en) begin
         column_ff <= col_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         luma_out[j] = mnr_pkg::luma(column_ff[j]);
      end
   end

   assign col_out = column_ff;

endmodule

>>> rtl/mnr_median.sv
// rank based median of the unmasked window lumas, registered
// depends on mnr_pkg
module mnr_median (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [mnr_pkg::WIN_SIZE-1:0][7:0]     luma_in,
   input  logic [mnr_pkg::WIN_SIZE-1:0]          mask_in,
   output logic [7:0]                            med
);

   logic [7:0] med_ff;
   logic [7:0] med_in;
   logic [mnr_pkg::WIN_SIZE-1:0][mnr_pkg::WIN_SIZE-1:0] lt;
   logic [mnr_pkg::WIN_SIZE-1:0][mnr_pkg::WIN_SIZE-1:0] le;
   logic [3:0] half;

   always_comb begin
      half = 4'($countones(mask_in)) >> 1;
      med_in = '0;
      for (int e = 0; e < mnr_pkg::WIN_SIZE; e++) begin
         for (int k = 0; k < mnr_pkg::WIN_SIZE; k++) begin
            lt[e][k] = mask_in[k] && (luma_in[k] < luma_in[e]);
            le[e][k] = mask_in[k] && (luma_in[k] <= luma_in[e]);
         end
      end
      // element holding sorted position half; ties give the same value
      for (int e = 0; e < mnr_pkg::WIN_SIZE; e++) begin
         if (mask_in[e] && (4'($countones(lt[e])) <= half)
               && (4'($countones(le[e])) > half)) begin
            med_in = med_in | luma_in[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         med_ff <= med_in;
      end
   end

   assign med = med_ff;

endmodule
